>>> hw/rtl/acw_pkg.sv
`timescale 1ns / 1ps
// shared widths, command and register codes, and controller states for the crop window block
package acw_pkg;

  localparam int SIDE_W   = 14;                 // image and window sides
  localparam int EDGE_W   = 13;                 // window left and top
  localparam int TERM_W   = 11;                 // aspect ratio terms
  localparam int PROD_W   = SIDE_W + TERM_W;    // side times ratio term
  localparam int DIVS_W   = TERM_W + 1;         // divisor, twice a ratio term
  localparam int DIVD_W   = PROD_W + 2;         // twice the product plus a term
  localparam int POS_W    = 17;                 // signed edge before clamping
  localparam int STEP_W   = 15;                 // signed move and size steps
  localparam int CMD_W    = 2;
  localparam int CFG_W    = 2;

  localparam int MAX_SIDE = 8192;
  localparam int MIN_SIZE = 16;
  localparam int EDGE_MAX = 8191;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NUDGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCALE = 2'd2;

  localparam logic [CFG_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0] REG_RATIO_WIDTH  = 2'd2;
  localparam logic [CFG_W-1:0] REG_RATIO_HEIGHT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP_A,
    S_CMP_A_WAIT,
    S_CMP_B,
    S_CMP_B_WAIT,
    S_MUL,
    S_MUL_WAIT,
    S_DIV,
    S_DIV_WAIT,
    S_POS,
    S_PLACE,
    S_EMIT
  } state_t;

endpackage

>>> hw/rtl/acw_serial_mul.sv
`timescale 1ns / 1ps
// shift-add multiplier, one multiplier bit per cycle
module acw_serial_mul import acw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIDE_W-1:0] mcand,
  input  logic [TERM_W-1:0] mplier,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  localparam int CNT_W = $clog2(TERM_W + 1);
  localparam int HI_W  = PROD_W + 1 - TERM_W;

  logic [SIDE_W-1:0] mcand_q;
  logic [PROD_W:0]   acc;
  logic [CNT_W-1:0]  count;
  logic [HI_W:0]     sum;
  logic [PROD_W:0]   acc_next;

  // add the multiplicand into the high half when the current bit is set, then shift right
  assign sum      = {1'b0, acc[PROD_W:TERM_W]} + (acc[0] ? {2'b00, mcand_q} : '0);
  assign acc_next = {sum, acc[TERM_W-1:1]};
  assign product  = acc[PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= !start && (count == CNT_W'(1));
      if (start) begin
        count <= CNT_W'(TERM_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_q <= mcand;
      acc     <= {{HI_W{1'b0}}, mplier};
    end else if (count != '0) begin
      acc <= acc_next;
    end
  end

endmodule

>>> hw/rtl/acw_serial_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module acw_serial_div import acw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] dvsr_q;
  logic [DIVS_W-1:0] rem;
  logic [DIVD_W-1:0] quo;
  logic [CNT_W-1:0]  count;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              fits;

  assign trial    = {rem, quo[DIVD_W-1]};
  assign diff     = trial - {1'b0, dvsr_q};
  assign fits     = trial >= {1'b0, dvsr_q};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= !start && (count == CNT_W'(1));
      if (start) begin
        count <= CNT_W'(DIVD_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr_q <= divisor;
      rem    <= '0;
      quo    <= dividend;
    end else if (count != '0) begin
      rem <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo <= {quo[DIVD_W-2:0], fits};
    end
  end

endmodule

>>> hw/rtl/aspect_locked_crop_window_top.sv
`timescale 1ns / 1ps
// top level of the aspect-locked crop window: config, controller, placement and result register
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   cfg     | in        | cfg_we             | cfg_addr, cfg_data
//   in      | in        | in_valid/in_ready  | cmd, move_x, move_y, size_step
//   out     | out       | out_valid/out_ready| win_left, win_top, win_width, win_height,
//           |           |                    | accepted
//
// one command at a time; init runs both compare multiplies, the side multiply and the divide,
// scale the multiply and divide, nudge neither, a scale refused on its width or an unused none
// the shift-add multiplier takes one ratio bit a cycle (twice for the init compare, once for
// the derived side) and the restoring divider one of 27 quotient bits a cycle
// synchronous reset restores the default image and ratio and an empty window at 0,0
// in_ready stays high while idle; a finished result holds in emit until the output is free
module aspect_locked_crop_window_top import acw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_addr,
  input  logic [SIDE_W-1:0]        cfg_data,
  // command beats
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [STEP_W-1:0] move_x,
  input  logic signed [STEP_W-1:0] move_y,
  input  logic signed [STEP_W-1:0] size_step,
  // result beats
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [EDGE_W-1:0]        win_left,
  output logic [EDGE_W-1:0]        win_top,
  output logic [SIDE_W-1:0]        win_width,
  output logic [SIDE_W-1:0]        win_height,
  output logic                     accepted
);

  // clamp an edge so the window lies inside the span, pinned at 0 when it cannot fit
  function automatic logic [EDGE_W-1:0] place_edge(input logic signed [POS_W-1:0] pos,
                                                   input logic [SIDE_W-1:0] size,
                                                   input logic [SIDE_W-1:0] span);
    logic signed [POS_W-1:0] p;
    logic signed [POS_W-1:0] lim;
    p   = (pos < 0) ? '0 : pos;
    lim = $signed({3'b000, span}) - $signed({3'b000, size});
    if (p > lim) p = lim;
    if (p < 0) p = '0;
    if (p > $signed(POS_W'(EDGE_MAX))) p = $signed(POS_W'(EDGE_MAX));
    return p[EDGE_W-1:0];
  endfunction

  // image sides saturate to 1..MAX_SIDE, a zero ratio term counts as 1
  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  function automatic logic [TERM_W-1:0] term_of(input logic [TERM_W-1:0] v);
    return (v == '0) ? TERM_W'(1) : v;
  endfunction

  // configuration registers
  logic [SIDE_W-1:0] image_width;
  logic [SIDE_W-1:0] image_height;
  logic [TERM_W-1:0] ratio_width;
  logic [TERM_W-1:0] ratio_height;

  logic [SIDE_W-1:0] iw;
  logic [SIDE_W-1:0] ih;
  logic [TERM_W-1:0] rw;
  logic [TERM_W-1:0] rh;

  // window state
  logic [EDGE_W-1:0] left_edge;
  logic [EDGE_W-1:0] top_edge;
  logic [SIDE_W-1:0] crop_width;
  logic [SIDE_W-1:0] crop_height;

  // controller
  state_t state;
  state_t state_next;

  // per-command working registers
  logic [CMD_W-1:0]         cmd_q;
  logic signed [STEP_W-1:0] move_x_q;
  logic signed [STEP_W-1:0] move_y_q;
  logic [SIDE_W-1:0]        nw_q;
  logic                     ok;
  logic                     keep_height;
  logic [SIDE_W-1:0]        sel_n;
  logic [TERM_W-1:0]        sel_a;
  logic [TERM_W-1:0]        sel_b;
  logic [PROD_W-1:0]        prod_a;
  logic [DIVD_W-1:0]        dividend_q;
  logic [SIDE_W-1:0]        new_w;
  logic [SIDE_W-1:0]        new_h;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;

  // combinational
  logic                     accept;
  logic                     emit_load;
  logic                     mul_start;
  logic [SIDE_W-1:0]        mul_n;
  logic [TERM_W-1:0]        mul_a;
  logic                     mul_done;
  logic [PROD_W-1:0]        mul_product;
  logic                     div_start;
  logic                     div_done;
  logic [DIVD_W-1:0]        div_quo;
  logic signed [SIDE_W+1:0] nw_full;
  logic                     nw_ok;
  logic [SIDE_W-1:0]        w_calc;
  logic [SIDE_W-1:0]        h_calc;
  logic signed [POS_W-1:0]  x_calc;
  logic signed [POS_W-1:0]  y_calc;
  logic [SIDE_W:0]          x_slack;
  logic [SIDE_W:0]          y_slack;

  assign iw = side_of(image_width);
  assign ih = side_of(image_height);
  assign rw = term_of(ratio_width);
  assign rh = term_of(ratio_height);

  assign accept = in_valid && in_ready;

  // requested width for scale, checked against the minimum and the image width on the
  // accepting edge, so a width that passes always fits the side field
  assign nw_full = $signed({2'b00, crop_width}) + $signed({size_step[STEP_W-1], size_step});
  assign nw_ok   = !nw_full[SIDE_W+1] && (nw_full[SIDE_W:0] >= (SIDE_W+1)'(MIN_SIZE))
                && (nw_full[SIDE_W:0] <= {1'b0, iw});

  acw_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_n),
    .mplier  (mul_a),
    .done    (mul_done),
    .product (mul_product)
  );

  acw_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend_q),
    .divisor  ({sel_b, 1'b0}),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_INIT:  state_next = S_CMP_A;
            CMD_NUDGE: state_next = S_POS;
            CMD_SCALE: state_next = nw_ok ? S_MUL : S_EMIT;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_CMP_A:      state_next = S_CMP_A_WAIT;
      S_CMP_A_WAIT: if (mul_done) state_next = S_CMP_B;
      S_CMP_B:      state_next = S_CMP_B_WAIT;
      S_CMP_B_WAIT: if (mul_done) state_next = S_MUL;
      S_MUL:        state_next = S_MUL_WAIT;
      S_MUL_WAIT:   if (mul_done) state_next = S_DIV;
      S_DIV:        state_next = S_DIV_WAIT;
      S_DIV_WAIT:   if (div_done) state_next = S_POS;
      S_POS:        state_next = S_PLACE;
      S_PLACE:      state_next = S_EMIT;
      S_EMIT:       if (!out_valid || out_ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    mul_n     = '0;
    mul_a     = '0;
    div_start = 1'b0;
    emit_load = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_CMP_A: begin
        mul_start = 1'b1;
        mul_n     = iw;
        mul_a     = rh;
      end
      S_CMP_B: begin
        mul_start = 1'b1;
        mul_n     = ih;
        mul_a     = rw;
      end
      S_MUL: begin
        mul_start = 1'b1;
        mul_n     = sel_n;
        mul_a     = sel_a;
      end
      S_DIV:  div_start = 1'b1;
      S_EMIT: emit_load = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  // candidate window and unclamped edges for the command in hand
  always_comb begin
    w_calc  = crop_width;
    h_calc  = crop_height;
    x_slack = {1'b0, iw} - {1'b0, w_calc};
    y_slack = {1'b0, ih} - {1'b0, h_calc};
    x_calc  = $signed({4'b0000, left_edge});
    y_calc  = $signed({4'b0000, top_edge});
    case (cmd_q)
      CMD_INIT: begin
        w_calc  = keep_height ? div_quo[SIDE_W-1:0] : iw;
        h_calc  = keep_height ? ih : div_quo[SIDE_W-1:0];
        x_slack = {1'b0, iw} - {1'b0, w_calc};
        y_slack = {1'b0, ih} - {1'b0, h_calc};
        // centred: half the leftover span
        x_calc  = $signed({3'b000, x_slack[SIDE_W:1]});
        y_calc  = $signed({3'b000, y_slack[SIDE_W:1]});
      end
      CMD_NUDGE: begin
        x_calc = $signed({4'b0000, left_edge})
               + $signed({{2{move_x_q[STEP_W-1]}}, move_x_q});
        y_calc = $signed({4'b0000, top_edge})
               + $signed({{2{move_y_q[STEP_W-1]}}, move_y_q});
      end
      CMD_SCALE: begin
        // keep the centre of the old window
        w_calc = nw_q;
        h_calc = div_quo[SIDE_W-1:0];
        x_calc = $signed({4'b0000, left_edge}) + $signed({4'b0000, crop_width[SIDE_W-1:1]})
               - $signed({4'b0000, nw_q[SIDE_W-1:1]});
        y_calc = $signed({4'b0000, top_edge}) + $signed({4'b0000, crop_height[SIDE_W-1:1]})
               - $signed({4'b0000, div_quo[SIDE_W-1:1]});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIDE_W'(1920);
      image_height <= SIDE_W'(1080);
      ratio_width  <= TERM_W'(16);
      ratio_height <= TERM_W'(9);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_RATIO_WIDTH:  ratio_width  <= cfg_data[TERM_W-1:0];
        REG_RATIO_HEIGHT: ratio_height <= cfg_data[TERM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // window state, committed only when the command goes through
  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge   <= '0;
      top_edge    <= '0;
      crop_width  <= '0;
      crop_height <= '0;
    end else if (state == S_PLACE && ok) begin
      left_edge   <= place_edge(pos_x, new_w, iw);
      top_edge    <= place_edge(pos_y, new_h, ih);
      crop_width  <= new_w;
      crop_height <= new_h;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ok <= 1'b0;
    end else begin
      if (accept) begin
        ok <= (cmd == CMD_INIT) || (cmd == CMD_NUDGE);
      end else if (state == S_DIV_WAIT && div_done && cmd_q == CMD_SCALE) begin
        ok <= (div_quo >= DIVD_W'(MIN_SIZE)) && (nw_q <= iw)
           && (div_quo <= {{(DIVD_W-SIDE_W){1'b0}}, ih});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd;
      move_x_q <= move_x;
      move_y_q <= move_y;
      nw_q     <= nw_full[SIDE_W-1:0];
      sel_n    <= nw_full[SIDE_W-1:0];
      sel_a    <= rh;
      sel_b    <= rw;
    end
    if (state == S_CMP_A_WAIT && mul_done) begin
      prod_a <= mul_product;
    end
    // iw*rh against rw*ih picks which side spans the image
    if (state == S_CMP_B_WAIT && mul_done) begin
      keep_height <= prod_a > mul_product;
      if (prod_a > mul_product) begin
        sel_n <= ih;
        sel_a <= rw;
        sel_b <= rh;
      end else begin
        sel_n <= iw;
        sel_a <= rh;
        sel_b <= rw;
      end
    end
    // round half up: (2*n*a + b) / (2*b)
    if (state == S_MUL_WAIT && mul_done) begin
      dividend_q <= DIVD_W'({mul_product, 1'b0}) + DIVD_W'(sel_b);
    end
    if (state == S_POS) begin
      new_w <= w_calc;
      new_h <= h_calc;
      pos_x <= x_calc;
      pos_y <= y_calc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      win_left   <= left_edge;
      win_top    <= top_edge;
      win_width  <= crop_width;
      win_height <= crop_height;
      accepted   <= ok;
    end
  end

  // an accepted command always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted command did not start work");

  // emitting a result always raises out_valid
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> out_valid)
    else $error("result beat not presented");

  // the window never outgrows the largest image side
  a_window_bounded: assert property (@(posedge clk) disable iff (rst)
    (crop_width <= SIDE_W'(MAX_SIDE)) && (crop_height <= SIDE_W'(MAX_SIDE)))
    else $error("window side beyond image limit");

  // the multiplier only finishes while the controller waits for it
  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_CMP_A_WAIT || state == S_CMP_B_WAIT || state == S_MUL_WAIT))
    else $error("multiplier finished outside a wait state");

endmodule

>>> tb/tb_aspect_locked_crop_window_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the aspect-locked crop window, random handshakes and register settings
module tb_aspect_locked_crop_window_top;
  import acw_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int IDLE_PCT      = 26;
  localparam int SETTLE_CYCLES = 100;   // a little over the slowest command (init)
  localparam int STEADY_PHASE  = 4;     // random phase run with both sides never idling

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [STEP_W-1:0] STEP_MAX   = 15'h3FFF;
  localparam logic [STEP_W-1:0] STEP_MIN   = 15'h4000;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [STEP_W-1:0] dx;
    logic [STEP_W-1:0] dy;
    logic [STEP_W-1:0] step;
  } command_t;

  typedef struct packed {
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic              acc;
  } window_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_we    = 1'b0;
  logic [CFG_W-1:0]         cfg_addr  = '0;
  logic [SIDE_W-1:0]        cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         cmd       = '0;
  logic signed [STEP_W-1:0] move_x    = '0;
  logic signed [STEP_W-1:0] move_y    = '0;
  logic signed [STEP_W-1:0] size_step = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [EDGE_W-1:0]        win_left;
  logic [EDGE_W-1:0]        win_top;
  logic [SIDE_W-1:0]        win_width;
  logic [SIDE_W-1:0]        win_height;
  logic                     accepted;

  command_t cmd_backlog[$];   // commands waiting for the driver
  window_t  due_windows[$];   // predicted windows, oldest first
  bit       steady      = 1'b0;
  int       fail_count  = 0;
  int       cycle_count = 0;

  // predictor copy of the registers, at their reset values
  logic [SIDE_W-1:0] img_w_reg   = SIDE_W'(1920);
  logic [SIDE_W-1:0] img_h_reg   = SIDE_W'(1080);
  logic [TERM_W-1:0] ratio_w_reg = TERM_W'(16);
  logic [TERM_W-1:0] ratio_h_reg = TERM_W'(9);

  // predictor copy of the window, empty at 0,0 after reset
  longint crop_left = 0;
  longint crop_top  = 0;
  longint crop_w    = 0;
  longint crop_h    = 0;

  aspect_locked_crop_window_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .move_x     (move_x),
    .move_y     (move_y),
    .size_step  (size_step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .win_left   (win_left),
    .win_top    (win_top),
    .win_width  (win_width),
    .win_height (win_height),
    .accepted   (accepted)
  );

  always #2 clk = ~clk;

  // image side as the block uses it: saturated to 1..MAX_SIDE
  function automatic longint clamp_side(logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (longint'(v) > MAX_SIDE) return MAX_SIDE;
    return longint'(v);
  endfunction

  // n*a/b rounded half away from zero, exact
  function automatic longint round_ratio(longint n, longint a, longint b);
    return (2 * n * a + b) / (2 * b);
  endfunction

  // clamp an edge so the window sits inside the span; a window wider than the span pins at 0
  function automatic longint fit_edge(longint pos, longint size, longint span);
    longint p;
    p = pos;
    if (p < 0) p = 0;
    if (p + size > span) p = span - size;
    if (p < 0) p = 0;
    if (p > EDGE_MAX) p = EDGE_MAX;
    return p;
  endfunction

  // apply one command to the predicted window and return the result beat it should give
  function automatic window_t advance_window(logic [CMD_W-1:0] op, longint mx, longint my,
                                             longint st);
    longint  iw, ih, rw, rh, w, h, nw, nh, cx, cy;
    logic    ok;
    window_t r;
    iw = clamp_side(img_w_reg);
    ih = clamp_side(img_h_reg);
    rw = (ratio_w_reg == '0) ? 1 : longint'(ratio_w_reg);
    rh = (ratio_h_reg == '0) ? 1 : longint'(ratio_h_reg);
    ok = 1'b0;
    case (op)
      CMD_INIT: begin
        // image wider than the ratio: keep full height, else full width
        if (iw * rh > rw * ih) begin
          h = ih;
          w = round_ratio(ih, rw, rh);
        end else begin
          w = iw;
          h = round_ratio(iw, rh, rw);
        end
        crop_w    = w;
        crop_h    = h;
        crop_left = fit_edge((iw - w) / 2, w, iw);
        crop_top  = fit_edge((ih - h) / 2, h, ih);
        ok        = 1'b1;
      end
      CMD_NUDGE: begin
        crop_left = fit_edge(crop_left + mx, crop_w, iw);
        crop_top  = fit_edge(crop_top + my, crop_h, ih);
        ok        = 1'b1;
      end
      CMD_SCALE: begin
        nw = crop_w + st;
        if (nw >= MIN_SIZE) begin
          nh = round_ratio(nw, rh, rw);
          if (nh >= MIN_SIZE && nw <= iw && nh <= ih) begin
            cx        = crop_left + crop_w / 2;
            cy        = crop_top + crop_h / 2;
            crop_w    = nw;
            crop_h    = nh;
            crop_left = fit_edge(cx - nw / 2, nw, iw);
            crop_top  = fit_edge(cy - nh / 2, nh, ih);
            ok        = 1'b1;
          end
        end
      end
      default: begin
        // unused code leaves the window alone
      end
    endcase
    r.left   = EDGE_W'(crop_left);
    r.top    = EDGE_W'(crop_top);
    r.width  = SIDE_W'(crop_w);
    r.height = SIDE_W'(crop_h);
    r.acc    = ok;
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] rnd_step();
    return STEP_W'($urandom_range(32767));
  endfunction

  // small signed offset in -lim..lim
  function automatic logic [STEP_W-1:0] near_step(int lim);
    return STEP_W'(int'($urandom_range(2 * lim)) - lim);
  endfunction

  function automatic logic [SIDE_W-1:0] pick_side();
    if ($urandom_range(99) < 85) return SIDE_W'($urandom_range(MAX_SIDE, MIN_SIZE));
    // out of range and boundary sides
    case ($urandom_range(4))
      0:       return '0;
      1:       return SIDE_W'(1);
      2:       return SIDE_W'(MIN_SIZE);
      3:       return SIDE_W'(MAX_SIDE + 1);
      default: return '1;
    endcase
  endfunction

  function automatic logic [SIDE_W-1:0] pick_term();
    int r;
    r = $urandom_range(99);
    if (r < 70) return SIDE_W'($urandom_range(20, 1));
    if (r < 88) return SIDE_W'($urandom_range(1024, 1));
    // zero term, widest term, or stray bits above the ratio field
    case ($urandom_range(2))
      0:       return '0;
      1:       return SIDE_W'(2047);
      default: return SIDE_W'($urandom_range(16383));
    endcase
  endfunction

  function automatic void push_cmd(logic [CMD_W-1:0] op, logic [STEP_W-1:0] dx,
                                   logic [STEP_W-1:0] dy, logic [STEP_W-1:0] step);
    command_t c;
    c.op   = op;
    c.dx   = dx;
    c.dy   = dy;
    c.step = step;
    cmd_backlog.push_back(c);
  endfunction

  task automatic write_reg(logic [CFG_W-1:0] idx, logic [SIDE_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_IMAGE_WIDTH:  img_w_reg = val;
      REG_IMAGE_HEIGHT: img_h_reg = val;
      REG_RATIO_WIDTH:  ratio_w_reg = val[TERM_W-1:0];
      default:          ratio_h_reg = val[TERM_W-1:0];
    endcase
  endtask

  // write the registers picked by mask, then release the write enable
  task automatic program_regs(logic [3:0] mask, logic [SIDE_W-1:0] iw, logic [SIDE_W-1:0] ih,
                              logic [SIDE_W-1:0] rw, logic [SIDE_W-1:0] rh);
    if (mask[0]) write_reg(REG_IMAGE_WIDTH, iw);
    if (mask[1]) write_reg(REG_IMAGE_HEIGHT, ih);
    if (mask[2]) write_reg(REG_RATIO_WIDTH, rw);
    if (mask[3]) write_reg(REG_RATIO_HEIGHT, rh);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block until every queued command is taken and every predicted window has come back
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || due_windows.size() != 0);
  endtask

  // command driver: predicts at the accepting edge, then offers the next beat or idles
  always @(posedge clk) begin : drive_commands
    command_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_windows.push_back(advance_window(cmd, move_x, move_y, size_step));
      end
      // a held beat keeps its payload; only a free slot may take a new one or idle
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = cmd_backlog.pop_front();
          in_valid  <= 1'b1;
          cmd       <= nxt.op;
          move_x    <= nxt.dx;
          move_y    <= nxt.dy;
          size_step <= nxt.step;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares every result beat with the oldest predicted window
  always @(posedge clk) begin : check_results
    window_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_windows.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = due_windows.pop_front();
          if (win_left !== want.left) begin
            $error("win_left expected %0d got %0d", want.left, win_left);
            fail_count++;
          end
          if (win_top !== want.top) begin
            $error("win_top expected %0d got %0d", want.top, win_top);
            fail_count++;
          end
          if (win_width !== want.width) begin
            $error("win_width expected %0d got %0d", want.width, win_width);
            fail_count++;
          end
          if (win_height !== want.height) begin
            $error("win_height expected %0d got %0d", want.height, win_height);
            fail_count++;
          end
          if (accepted !== want.acc) begin
            $error("accepted expected %0d got %0d", want.acc, accepted);
            fail_count++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int                sent;
    int                span;
    int                phase;
    int                roll;
    logic [CMD_W-1:0]  op;
    logic [STEP_W-1:0] dx;
    logic [STEP_W-1:0] dy;
    logic [STEP_W-1:0] st;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default 1920x1080 at 16:9, window still empty from reset
    push_cmd(CMD_NUDGE, STEP_W'(5), STEP_W'(7), rnd_step());       // empty window moves freely
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), '0);               // zero width, refused
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_W'(320));     // grows out of the empty window
    push_cmd(CMD_UNUSED, rnd_step(), rnd_step(), rnd_step());
    push_cmd(CMD_INIT, rnd_step(), rnd_step(), rnd_step());
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_MAX);         // wider than the image
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_MIN);         // negative width
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_W'(-1904));   // width ok, height too small
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_W'(-1000));   // height lands on a half
    push_cmd(CMD_NUDGE, STEP_MAX, STEP_MIN, rnd_step());
    push_cmd(CMD_NUDGE, STEP_MIN, STEP_MAX, rnd_step());
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_W'(1000));    // back to the full image
    drain();

    // zero sides and terms read as a 1x1 image at 1:1
    program_regs(4'hF, '0, '0, '0, '0);
    push_cmd(CMD_INIT, rnd_step(), rnd_step(), rnd_step());
    push_cmd(CMD_NUDGE, STEP_W'(3), STEP_W'(3), rnd_step());
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_W'(15));
    drain();

    // oversized width register, 1-pixel height, stray ratio bits: init rounds the width to 0
    program_regs(4'hF, '1, '0, SIDE_W'(14'h3801), SIDE_W'(2047));
    push_cmd(CMD_INIT, rnd_step(), rnd_step(), rnd_step());
    push_cmd(CMD_NUDGE, STEP_MIN, STEP_W'(100), rnd_step());
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_W'(8192));
    drain();

    // largest image, square 1024:1024 ratio
    program_regs(4'hF, SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), SIDE_W'(1024), SIDE_W'(1024));
    push_cmd(CMD_INIT, rnd_step(), rnd_step(), rnd_step());
    push_cmd(CMD_NUDGE, STEP_W'(-1), STEP_W'(-1), rnd_step());
    drain();

    // image shrinks under the window: edges pin at 0 until it is scaled down
    program_regs(4'b0011, SIDE_W'(MIN_SIZE), SIDE_W'(MIN_SIZE), '0, '0);
    push_cmd(CMD_NUDGE, STEP_W'(100), STEP_W'(100), rnd_step());
    push_cmd(CMD_SCALE, rnd_step(), rnd_step(), STEP_W'(-8176));
    drain();

    // random phases, each with its own register setting, drained before the next one
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        program_regs(4'hF, pick_side(), pick_side(), pick_term(), pick_term());
      end else if (roll < 80) begin
        program_regs(4'($urandom_range(15)), pick_side(), pick_side(), pick_term(), pick_term());
      end
      steady = (phase == STEADY_PHASE);
      span = steady ? 150 : int'($urandom_range(120, 30));
      if (span > RANDOM_ITEMS - sent) span = RANDOM_ITEMS - sent;
      // most phases start from a fresh centred window so scale and nudge have room
      if ($urandom_range(9) < 7) begin
        push_cmd(CMD_INIT, rnd_step(), rnd_step(), rnd_step());
        sent++;
      end
      for (int k = 0; k < span; k++) begin
        roll = $urandom_range(99);
        if (roll < 8) op = CMD_INIT;
        else if (roll < 48) op = CMD_NUDGE;
        else if (roll < 93) op = CMD_SCALE;
        else op = CMD_UNUSED;
        dx = rnd_step();
        dy = rnd_step();
        st = rnd_step();
        if (op == CMD_NUDGE && $urandom_range(4) != 0) begin
          dx = near_step(500);
          dy = near_step(500);
        end
        if (op == CMD_SCALE && $urandom_range(3) != 0) st = near_step(300);
        push_cmd(op, dx, dy, st);
      end
      sent += span;
      drain();
      phase++;
    end
    steady = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/acw_pkg.sv
hw/rtl/acw_serial_mul.sv
hw/rtl/acw_serial_div.sv
hw/rtl/aspect_locked_crop_window_top.sv
tb/tb_aspect_locked_crop_window_top.sv
